// ===== rtl/core/uart_rf_pkg.sv =====
// ----------------------------------------------------------------------------
// UART register file package
// Shared types, register codes and the interrupt identification function.
// ----------------------------------------------------------------------------
package uart_rf_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_DATA = 3'd0,
    REG_IER  = 3'd1,
    REG_IIR  = 3'd2,
    REG_LCR  = 3'd3,
    REG_MCR  = 3'd4,
    REG_LSR  = 3'd5,
    REG_MSR  = 3'd6,
    REG_SCR  = 3'd7
  } reg_e;

  localparam logic [7:0] LSR_RESET    = 8'h60;
  localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
  localparam logic [7:0] IIR_RESET    = 8'h01;
  localparam logic [7:0] IIR_NONE     = 8'hC1;
  localparam logic [7:0] IIR_THRE     = 8'hC2;
  localparam logic [7:0] IIR_RXDATA   = 8'hC4;
  localparam logic [7:0] MSR_FIXED    = 8'h30;
  localparam int unsigned DLAB_BIT    = 7;
  localparam int unsigned FCR_RX_CLR  = 1;
  localparam int unsigned FCR_TX_CLR  = 2;
  localparam int unsigned LSR_DR      = 0;
  localparam int unsigned LSR_TX_RDY  = 5;
  localparam int unsigned IER_RX      = 0;
  localparam int unsigned IER_THRE    = 1;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pop;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic [4:0] rx_space;
  } result_t;

  function automatic logic [7:0] iir_calc(logic [3:0] ier, logic [7:0] lsr);
    logic [7:0] v;
    v = IIR_NONE;
    if (ier[IER_THRE] && lsr[LSR_TX_RDY]) v = IIR_THRE;
    if (ier[IER_RX] && lsr[LSR_DR]) v = IIR_RXDATA;
    return v;
  endfunction

endpackage

// ===== rtl/core/uart_rf_rx_mem.sv =====
// ----------------------------------------------------------------------------
// UART receive FIFO storage
// Single-port-write, single-port-read synchronous memory with registered read.
// ----------------------------------------------------------------------------
module uart_rf_rx_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/uart_rf_regs.sv =====
// ----------------------------------------------------------------------------
// UART register file control
// Holds UART regs and FIFO pointers; commits one beat per accepted cycle.
// ----------------------------------------------------------------------------
module uart_rf_regs
  import uart_rf_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    op_i,
  input  logic [2:0]    reg_sel_i,
  input  logic [7:0]    write_data_i,
  input  logic [7:0]    rx_byte_i,
  output logic          mem_we_o,
  output logic [PW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [PW-1:0] mem_raddr_o,
  output result_t       result_o
);

  localparam int unsigned SW = (CW > 5) ? CW : 5;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    lsr_q, lsr_d, iir_q, iir_d;
  logic [3:0]    ier_q, ier_d;
  logic [7:0]    lcr_q, lcr_d, mcr_q, mcr_d, scr_q, scr_d;
  logic [7:0]    dll_q, dll_d, dlm_q, dlm_d;
  logic          recalc, push, pop, full, empty, dlab;
  logic [SW-1:0] space;
  op_e           op;
  reg_e          ridx;

  function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign op    = op_e'(op_i);
  assign ridx  = reg_e'(reg_sel_i);
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign dlab  = lcr_q[DLAB_BIT];

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    lsr_d    = lsr_q;
    ier_d    = ier_q;
    lcr_d    = lcr_q;
    mcr_d    = mcr_q;
    scr_d    = scr_q;
    dll_d    = dll_q;
    dlm_d    = dlm_q;
    recalc   = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    result_o = '0;

    unique case (op)
      OP_READ: begin
        if (dlab && ridx == REG_DATA) begin
          result_o.read_data = dll_q;
        end else if (dlab && ridx == REG_IER) begin
          result_o.read_data = dlm_q;
        end else begin
          unique case (ridx)
            REG_DATA: begin
              if (!empty) begin
                pop     = 1'b1;
                head_d  = next_ptr(head_q);
                count_d = count_q - 1'b1;
                if (count_q == CW'(1)) lsr_d[LSR_DR] = 1'b0;
                recalc  = 1'b1;
              end
            end
            REG_IER: result_o.read_data = {4'b0, ier_q};
            REG_IIR: result_o.read_data = iir_q;
            REG_LCR: result_o.read_data = lcr_q;
            REG_MCR: result_o.read_data = mcr_q;
            REG_LSR: result_o.read_data = lsr_q;
            REG_MSR: result_o.read_data = MSR_FIXED;
            default: result_o.read_data = scr_q;
          endcase
        end
      end
      OP_WRITE: begin
        if (dlab && ridx == REG_DATA) begin
          dll_d = write_data_i;
        end else if (dlab && ridx == REG_IER) begin
          dlm_d = write_data_i;
        end else begin
          unique case (ridx)
            REG_DATA: begin
              result_o.tx_valid = 1'b1;
              result_o.tx_byte  = write_data_i;
              lsr_d             = lsr_q | LSR_TX_EMPTY;
              recalc            = 1'b1;
            end
            REG_IER: begin
              ier_d  = write_data_i[3:0];
              recalc = 1'b1;
            end
            REG_IIR: begin
              if (write_data_i[FCR_RX_CLR]) begin
                head_d        = '0;
                tail_d        = '0;
                count_d       = '0;
                lsr_d[LSR_DR] = 1'b0;
              end
              if (write_data_i[FCR_TX_CLR]) lsr_d = lsr_d | LSR_TX_EMPTY;
            end
            REG_LCR: lcr_d = write_data_i;
            REG_MCR: mcr_d = write_data_i;
            REG_SCR: scr_d = write_data_i;
            default: ;
          endcase
        end
      end
      OP_RX: begin
        if (full) begin
          result_o.rx_dropped = 1'b1;
        end else begin
          push          = 1'b1;
          tail_d        = next_ptr(tail_q);
          count_d       = count_q + 1'b1;
          lsr_d[LSR_DR] = 1'b1;
          recalc        = 1'b1;
        end
      end
      default: ;
    endcase

    iir_d             = recalc ? iir_calc(ier_d, lsr_d) : iir_q;
    space             = SW'(DEPTH) - SW'(count_d);
    result_o.rx_space = space[4:0];
    result_o.pop      = pop;
  end

  assign mem_we_o    = accept_i && push;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = rx_byte_i;
  assign mem_re_o    = accept_i && pop;
  assign mem_raddr_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      lsr_q   <= LSR_RESET;
      iir_q   <= IIR_RESET;
      ier_q   <= '0;
      lcr_q   <= '0;
      mcr_q   <= '0;
      scr_q   <= '0;
      dll_q   <= '0;
      dlm_q   <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      lsr_q   <= lsr_d;
      iir_q   <= iir_d;
      ier_q   <= ier_d;
      lcr_q   <= lcr_d;
      mcr_q   <= mcr_d;
      scr_q   <= scr_d;
      dll_q   <= dll_d;
      dlm_q   <= dlm_d;
    end
  end

endmodule

// ===== rtl/core/uart_register_file_rx_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// UART register file with receive FIFO
// Bus reads, bus writes and received bytes enter as beats; each gives one beat.
// ----------------------------------------------------------------------------
// A result beat is presented in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless m_axis_tready stalls a held result; the
// output register and the registered FIFO read port are the only stage.
// Reset clears the UART registers, FIFO pointers and output valid flag at once,
// not the output data or FIFO storage; storage is never read before written.
module uart_register_file_rx_fifo_unit
  import uart_rf_pkg::*;
#(
  parameter int unsigned RX_FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_sel[2:0], write_data[10:3], rx_byte[18:11], zero[23:19]
  input  logic [23:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], tx_valid[8], tx_byte[16:9], rx_dropped[17], rx_space[22:18],
  // zero[23]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned PW = $clog2(RX_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(RX_FIFO_DEPTH + 1);

  logic          accept;
  logic          out_valid_q;
  result_t       result, result_q;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata, read_data;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  uart_rf_regs #(
    .DEPTH(RX_FIFO_DEPTH),
    .PW   (PW),
    .CW   (CW)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (s_axis_tuser),
    .reg_sel_i   (s_axis_tdata[2:0]),
    .write_data_i(s_axis_tdata[10:3]),
    .rx_byte_i   (s_axis_tdata[18:11]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .result_o    (result)
  );

  uart_rf_rx_mem #(
    .DEPTH(RX_FIFO_DEPTH),
    .AW   (PW)
  ) u_rx_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign read_data     = result_q.pop ? mem_rdata : result_q.read_data;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q.rx_space, result_q.rx_dropped,
                          result_q.tx_byte, result_q.tx_valid, read_data};

endmodule

// ===== rtl/core/uart_rf_checker.sv =====
// ----------------------------------------------------------------------------
// UART register file port checker
// Checks output beat consistency and handshake timing on the top-level ports.
// ----------------------------------------------------------------------------
module uart_rf_checker
  import uart_rf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [1:0] in_op;

  assign in_op = s_axis_tuser;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result beat");

  a_tx_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |->
      m_axis_tdata[7:0] == 8'h00 && !m_axis_tdata[17])
    else $error("transmit beat carries read data or drop flag");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |->
      m_axis_tdata[22:18] == 5'd0 && m_axis_tdata[16:0] == 17'd0)
    else $error("dropped byte reported with free space or other data");

  a_idle_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_op == OP_IDLE |=>
      m_axis_tdata[17:0] == 18'd0)
    else $error("unused operation produced data");

endmodule

bind uart_register_file_rx_fifo_unit uart_rf_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
